// ===== sv/wvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wvsd_pkg
// Shared types and constants for the wind vector to speed/direction pipeline.
// ----------------------------------------------------------------------------
package wvsd_pkg;

  // Component width of the signed u/v inputs
  localparam int COMPONENT_WIDTH = 16;
  // Requested CORDIC iterations; the angle table bounds the usable count
  localparam int CORDIC_STAGES   = 16;

  localparam int CW         = COMPONENT_WIDTH;
  localparam int ATAN_LEN   = 24;
  localparam int CORDIC_N   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int GUARD_BITS = 60 - CW;

  // Iterative section: CORDIC and square root run side by side
  localparam int MID_STAGES  = (CORDIC_N > CW) ? CORDIC_N : CW;
  // abs, squares, sum, iterations, finish, output
  localparam int PIPE_STAGES = MID_STAGES + 5;

  // CORDIC datapath widths
  localparam int XY_W  = 62;
  localparam int XU_W  = XY_W - 1;
  localparam int ANG_W = 32;

  // Square root widths
  localparam int SUM_W  = 2 * CW;
  localparam int REM_W  = CW + 2;
  localparam int PRE_W  = CW + 4;

  // Result formats
  localparam int SPEED_W    = 16;
  localparam int DIR_W      = 16;
  localparam int SPD_CALC_W = CW + SPEED_W + 1;
  localparam int RND_W      = ANG_W + 1;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [DIR_W-1:0]   DIR_MAX   = 16'd36000;

  // Angles in 2^-16 units of 0.01 degree
  localparam logic [ANG_W-1:0] ANG_90     = 32'd589824000;
  localparam logic [ANG_W-1:0] ANG_180    = 32'd1179648000;
  localparam logic [ANG_W-1:0] ANG_360    = 32'd2359296000;
  localparam logic [ANG_W-1:0] ROUND_HALF = 32'd32768;

  // atan(2^-i) in angle units
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
    32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
    32'd1466765,   32'd733385,    32'd366693,   32'd183346,
    32'd91673,     32'd45837,     32'd22918,    32'd11459,
    32'd5730,      32'd2865,      32'd1432,     32'd716,
    32'd358,       32'd179,       32'd90,       32'd45
  };

  // Quadrant and special-case flags carried alongside the data
  typedef struct packed {
    logic u_neg;
    logic v_neg;
    logic zero;
  } flags_t;

endpackage

// ===== sv/wvsd_if.sv =====
// ----------------------------------------------------------------------------
// wvsd_in_if / wvsd_out_if
// Valid/ready channels for wind components in and speed/direction out.
// ----------------------------------------------------------------------------
interface wvsd_in_if import wvsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] east_in;
  logic signed [CW-1:0] north_in;

  modport source (output valid, output east_in, output north_in, input ready);
  modport sink   (input valid, input east_in, input north_in, output ready);
endinterface

interface wvsd_out_if import wvsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_out;
  logic [DIR_W-1:0]   direction_out;

  modport source (output valid, output speed_out, output direction_out, input ready);
  modport sink   (input valid, input speed_out, input direction_out, output ready);
endinterface

// ===== sv/wvsd_cordic.sv =====
// ----------------------------------------------------------------------------
// wvsd_cordic
// Unrolled vectoring CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module wvsd_cordic import wvsd_pkg::*; (
  input  logic                    clk,
  input  logic [MID_STAGES-1:0]   en,
  input  logic [CW-1:0]           ax,
  input  logic [CW-1:0]           ay,
  output logic signed [ANG_W-1:0] z_o
);

  logic [XU_W-1:0]         x_in  [MID_STAGES];
  logic signed [XY_W-1:0]  y_in  [MID_STAGES];
  logic signed [ANG_W-1:0] z_in  [MID_STAGES];
  logic [XU_W-1:0]         x_nxt [MID_STAGES];
  logic signed [XY_W-1:0]  y_nxt [MID_STAGES];
  logic signed [ANG_W-1:0] z_nxt [MID_STAGES];
  logic [XU_W-1:0]         x_r   [MID_STAGES];
  logic signed [XY_W-1:0]  y_r   [MID_STAGES];
  logic signed [ANG_W-1:0] z_r   [MID_STAGES];

  // Start at x=|v|, y=|u| with guard bits below
  assign x_in[0] = XU_W'({ax, {GUARD_BITS{1'b0}}});
  assign y_in[0] = XY_W'({ay, {GUARD_BITS{1'b0}}});
  assign z_in[0] = '0;

  for (genvar k = 0; k < MID_STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign x_in[k] = x_r[k-1];
      assign y_in[k] = y_r[k-1];
      assign z_in[k] = z_r[k-1];
    end

    if (k < CORDIC_N) begin : g_iter
      logic            y_pos;
      logic [XY_W-1:0] y_mag;
      logic [XY_W-1:0] x_sh;

      assign y_pos = !y_in[k][XY_W-1] && (y_in[k] != '0);
      assign y_mag = y_in[k][XY_W-1] ? XY_W'(-y_in[k]) : XY_W'(y_in[k]);
      assign x_sh  = XY_W'(x_in[k] >> k);

      // x only grows: both rotation directions add |y| >> k
      assign x_nxt[k] = x_in[k] + XU_W'(y_mag >> k);
      assign y_nxt[k] = y_pos ? (y_in[k] - $signed(x_sh)) : (y_in[k] + $signed(x_sh));
      assign z_nxt[k] = y_pos ? (z_in[k] + $signed(ATAN_TAB[k]))
                              : (z_in[k] - $signed(ATAN_TAB[k]));
    end else begin : g_hold
      assign x_nxt[k] = x_in[k];
      assign y_nxt[k] = y_in[k];
      assign z_nxt[k] = z_in[k];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
  end

  assign z_o = z_r[MID_STAGES-1];

endmodule

// ===== sv/wvsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// wvsd_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module wvsd_isqrt import wvsd_pkg::*; (
  input  logic                  clk,
  input  logic [MID_STAGES-1:0] en,
  input  logic [SUM_W-1:0]      s,
  output logic [CW-1:0]         root_o,
  output logic [REM_W-1:0]      rem_o
);

  logic [SUM_W-1:0] s_in     [MID_STAGES];
  logic [CW-1:0]    root_in  [MID_STAGES];
  logic [REM_W-1:0] rem_in   [MID_STAGES];
  logic [SUM_W-1:0] s_nxt    [MID_STAGES];
  logic [CW-1:0]    root_nxt [MID_STAGES];
  logic [REM_W-1:0] rem_nxt  [MID_STAGES];
  logic [SUM_W-1:0] s_r      [MID_STAGES];
  logic [CW-1:0]    root_r   [MID_STAGES];
  logic [REM_W-1:0] rem_r    [MID_STAGES];

  assign s_in[0]    = s;
  assign root_in[0] = '0;
  assign rem_in[0]  = '0;

  for (genvar k = 0; k < MID_STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign s_in[k]    = s_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
    end

    if (k < CW) begin : g_step
      logic [PRE_W-1:0] pre;
      logic [PRE_W-1:0] trial;
      logic             ge;

      // Bring down the next two operand bits, try root*4+1
      assign pre   = {rem_in[k], s_in[k][SUM_W-1 -: 2]};
      assign trial = PRE_W'({root_in[k], 2'b01});
      assign ge    = (pre >= trial);

      assign rem_nxt[k]  = ge ? REM_W'(pre - trial) : REM_W'(pre);
      assign root_nxt[k] = {root_in[k][CW-2:0], ge};
      assign s_nxt[k]    = {s_in[k][SUM_W-3:0], 2'b00};
    end else begin : g_hold
      assign rem_nxt[k]  = rem_in[k];
      assign root_nxt[k] = root_in[k];
      assign s_nxt[k]    = s_in[k];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        s_r[k]    <= s_nxt[k];
        root_r[k] <= root_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

  assign root_o = root_r[MID_STAGES-1];
  assign rem_o  = rem_r[MID_STAGES-1];

endmodule

// ===== sv/wind_vector_to_speed_direction.sv =====
// Depth: 21 register stages; a result is presented once its input transaction
//   has passed through all of them.
// Throughput: one transaction per cycle while out_ch.ready is high; each CORDIC
//   iteration and each root bit has its own stage, so nothing is shared between items.
// Reset: rst_n (synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// wind_vector_to_speed_direction
// Converts u/v wind components into rounded speed and meteorological
// direction through a parallel CORDIC and square-root pipeline.
// ----------------------------------------------------------------------------
module wind_vector_to_speed_direction import wvsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wvsd_in_if.sink     in_ch,
  wvsd_out_if.source  out_ch
);

  localparam int ST_MID = 3;
  localparam int ST_FIN = ST_MID + MID_STAGES;
  localparam int ST_OUT = ST_FIN + 1;

  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] en;
  flags_t                 flg_r [ST_FIN+1];

  // Stage enables: a stage loads when empty or when its successor moves
  assign en[PIPE_STAGES-1] = ~vld_r[PIPE_STAGES-1] | out_ch.ready;
  for (genvar k = 0; k < PIPE_STAGES - 1; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 0: magnitudes and quadrant flags
  flags_t        flg_nxt;
  logic [CW-1:0] au_nxt, av_nxt;
  logic [CW-1:0] au_r, av_r;

  always_comb begin
    flg_nxt.u_neg = in_ch.east_in[CW-1];
    flg_nxt.v_neg = in_ch.north_in[CW-1];
    flg_nxt.zero  = (in_ch.east_in == '0) && (in_ch.north_in == '0);
    au_nxt = flg_nxt.u_neg ? CW'(~in_ch.east_in + 1'b1) : CW'(in_ch.east_in);
    av_nxt = flg_nxt.v_neg ? CW'(~in_ch.north_in + 1'b1) : CW'(in_ch.north_in);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      au_r     <= au_nxt;
      av_r     <= av_nxt;
      flg_r[0] <= flg_nxt;
    end
    for (int k = 1; k <= ST_FIN; k++) begin
      if (en[k]) begin
        flg_r[k] <= flg_r[k-1];
      end
    end
  end

  // Stage 1: squares; stage 2: sum of squares
  logic [CW-1:0]    au1_r, av1_r, au2_r, av2_r;
  logic [SUM_W-1:0] usq_r, vsq_r, sum_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      au1_r <= au_r;
      av1_r <= av_r;
      usq_r <= au_r * au_r;
      vsq_r <= av_r * av_r;
    end
    if (en[2]) begin
      au2_r <= au1_r;
      av2_r <= av1_r;
      sum_r <= usq_r + vsq_r;
    end
  end

  // Iterative section
  logic signed [ANG_W-1:0] z_w;
  logic [CW-1:0]           root_w;
  logic [REM_W-1:0]        rem_w;

  wvsd_cordic u_cordic (
    .clk (clk),
    .en  (en[ST_MID +: MID_STAGES]),
    .ax  (av2_r),
    .ay  (au2_r),
    .z_o (z_w)
  );

  wvsd_isqrt u_isqrt (
    .clk    (clk),
    .en     (en[ST_MID +: MID_STAGES]),
    .s      (sum_r),
    .root_o (root_w),
    .rem_o  (rem_w)
  );

  // Finish stage: clamp angle, place by quadrant, round speed
  logic [ANG_W-1:0]      a_clamp;
  logic [ANG_W-1:0]      d_nxt;
  logic [SPD_CALC_W-1:0] spd_wide;
  logic [SPEED_W-1:0]    spd_nxt;
  logic [ANG_W-1:0]      d_r;
  logic [SPEED_W-1:0]    spd_r;

  always_comb begin
    if (z_w[ANG_W-1]) begin
      a_clamp = '0;
    end else if (ANG_W'(z_w) > ANG_90) begin
      a_clamp = ANG_90;
    end else begin
      a_clamp = ANG_W'(z_w);
    end

    case ({flg_r[ST_FIN-1].u_neg, flg_r[ST_FIN-1].v_neg})
      2'b00:   d_nxt = ANG_180 + a_clamp;
      2'b01:   d_nxt = ANG_360 - a_clamp;
      2'b10:   d_nxt = ANG_180 - a_clamp;
      default: d_nxt = a_clamp;
    endcase

    // Round up when the remainder exceeds the floor root
    spd_wide = SPD_CALC_W'(root_w) + SPD_CALC_W'(rem_w > REM_W'(root_w));
    spd_nxt  = (spd_wide > SPD_CALC_W'(SPEED_MAX)) ? SPEED_MAX : spd_wide[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_FIN]) begin
      d_r   <= d_nxt;
      spd_r <= spd_nxt;
    end
  end

  // Output stage: round direction to 0.01 degree
  logic [RND_W-1:0]   d_rnd;
  logic [DIR_W-1:0]   dir_nxt;
  logic [DIR_W-1:0]   dir_r;
  logic [SPEED_W-1:0] spd_out_r;

  always_comb begin
    d_rnd   = RND_W'(d_r) + RND_W'(ROUND_HALF);
    dir_nxt = flg_r[ST_FIN].zero ? '0 : d_rnd[ANG_W-1 -: DIR_W];
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      dir_r     <= dir_nxt;
      spd_out_r <= spd_r;
    end
  end

  assign out_ch.valid         = vld_r[ST_OUT];
  assign out_ch.speed_out     = spd_out_r;
  assign out_ch.direction_out = dir_r;

endmodule

// ===== sv/wvsd_checker.sv =====
// ----------------------------------------------------------------------------
// wvsd_checker
// Port-level checks on transaction flow and direction range, bound to the top.
// ----------------------------------------------------------------------------
module wvsd_checker import wvsd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SPEED_W-1:0] speed,
  input logic [DIR_W-1:0]   direction
);

  localparam int CNT_W = $clog2(PIPE_STAGES + 1) + 1;

  logic [CNT_W-1:0] cnt_r;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(speed) && $stable(direction))
    else $error("result changed or dropped while stalled");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> direction <= DIR_MAX)
    else $error("direction out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a pending input");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PIPE_STAGES))
    else $error("more transactions in flight than pipeline stages");

endmodule

bind wind_vector_to_speed_direction wvsd_checker u_wvsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .speed     (out_ch.speed_out),
  .direction (out_ch.direction_out)
);
